>>> hw/rtl/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

    // Matrix order and number format
    localparam int DIM       = 4;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(DIM);

    // Accumulation widths: exact products, one pair level, then the full sum
    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(DIM);

    typedef logic signed [DATA_W-1:0] data_t;

    // One row of A and the matching row of B
    typedef struct packed {
        data_t left_col0;
        data_t left_col1;
        data_t left_col2;
        data_t left_col3;
        data_t right_col0;
        data_t right_col1;
        data_t right_col2;
        data_t right_col3;
    } row_item_t;

    // One row of C
    typedef struct packed {
        data_t            product_col0;
        data_t            product_col1;
        data_t            product_col2;
        data_t            product_col3;
        logic [ROW_W-1:0] product_row;
        logic             final_row;
    } prod_item_t;

    // Tag that follows a row down the lane pipeline
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } tag_t;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mm4_lane.sv
`default_nettype none

// One output column: DIM multipliers, a pair level, then the full sum.
module mm4_lane (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire mm4_pkg::data_t                    a_row [mm4_pkg::DIM],
    input  wire mm4_pkg::data_t                    b_col [mm4_pkg::DIM],
    output logic signed [mm4_pkg::SUM_W-1:0]       sum
);

    localparam int NPAIR = mm4_pkg::DIM / 2;

    logic signed [mm4_pkg::PROD_W-1:0] prod_reg  [mm4_pkg::DIM];
    logic signed [mm4_pkg::PROD_W-1:0] prod_next [mm4_pkg::DIM];
    logic signed [mm4_pkg::PAIR_W-1:0] pair_reg  [NPAIR];
    logic signed [mm4_pkg::PAIR_W-1:0] pair_next [NPAIR];
    logic signed [mm4_pkg::SUM_W-1:0]  sum_reg;
    logic signed [mm4_pkg::SUM_W-1:0]  sum_next;

    always_comb
    begin
        for (int k = 0; k < mm4_pkg::DIM; k++)
        begin
            prod_next[k] = mm4_pkg::PROD_W'(a_row[k]) * mm4_pkg::PROD_W'(b_col[k]);
        end
        for (int j = 0; j < NPAIR; j++)
        begin
            pair_next[j] = mm4_pkg::PAIR_W'(prod_reg[2*j]) + mm4_pkg::PAIR_W'(prod_reg[2*j+1]);
        end
        sum_next = '0;
        for (int j = 0; j < NPAIR; j++)
        begin
            sum_next = sum_next + mm4_pkg::SUM_W'(pair_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mm4_merge.sv
`default_nettype none

// Gathers the lane sums into one product row: shift, saturate, register.
module mm4_merge (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire mm4_pkg::tag_t                      tag,
    input  wire logic signed [mm4_pkg::SUM_W-1:0]   sums [mm4_pkg::DIM],
    output logic                                    valid,
    output mm4_pkg::prod_item_t                     item
);

    localparam int SUM_W  = mm4_pkg::SUM_W;
    localparam int DATA_W = mm4_pkg::DATA_W;

    function automatic mm4_pkg::data_t sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        logic [SUM_W-DATA_W:0]   hi;
        sh = s >>> mm4_pkg::FRAC_BITS;
        hi = sh[SUM_W-1:DATA_W-1];
        if (hi == '0 || hi == '1)
            return sh[DATA_W-1:0];
        else if (sh[SUM_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic                valid_reg;
    mm4_pkg::prod_item_t item_reg;
    mm4_pkg::prod_item_t item_next;

    always_comb
    begin
        item_next.product_col0 = sat(sums[0]);
        item_next.product_col1 = sat(sums[1]);
        item_next.product_col2 = sat(sums[2]);
        item_next.product_col3 = sat(sums[3]);
        item_next.product_row  = tag.row;
        item_next.final_row    = (tag.row == mm4_pkg::ROW_W'(mm4_pkg::DIM - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= tag.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/matrix_multiply_4x4_top.sv
`default_nettype none

// 4x4 signed Q16.16 matrix multiply, C = A x B. Each item on the row channel
// carries row r of A and row r of B, rows sent in order 0..3. After the fourth
// row the block issues one row of C per cycle, when the product side does not
// stall, into four column lanes, each with four 32x32 multipliers. A product
// row passes through multiply, pair add, full add, then shift and saturate
// into the output register. The row channel stalls only while the rows of C
// are issued; loading of the next pair may start while earlier product
// rows are still in the pipeline or waiting at the output. Sums are exact,
// shifted right by 16 (floor) and saturated to 32 bits. A stall on the
// product channel freezes the whole lane pipeline while a row is held.
module matrix_multiply_4x4_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 row_valid,
    output logic                      row_stall,
    input  wire mm4_pkg::row_item_t   row_item,
    output logic                      prod_valid,
    input  wire logic                 prod_stall,
    output mm4_pkg::prod_item_t       prod_item
);

    localparam int DIM   = mm4_pkg::DIM;
    localparam int ROW_W = mm4_pkg::ROW_W;

    // Control
    mm4_pkg::state_t  state_reg, state_next;
    logic [ROW_W-1:0] rows_loaded_reg, rows_loaded_next;
    logic [ROW_W-1:0] issue_row_reg, issue_row_next;
    mm4_pkg::tag_t    tag1_reg, tag2_reg, tag3_reg;
    mm4_pkg::tag_t    issue_tag;
    logic             en;
    logic             row_accept;

    // Operand stores, written one row per accepted item
    mm4_pkg::data_t left_reg  [DIM][DIM];
    mm4_pkg::data_t right_reg [DIM][DIM];
    mm4_pkg::data_t in_left   [DIM];
    mm4_pkg::data_t in_right  [DIM];

    // Lane operands and results
    mm4_pkg::data_t                    a_row [DIM];
    mm4_pkg::data_t                    b_col [DIM][DIM];
    logic signed [mm4_pkg::SUM_W-1:0]  lane_sum [DIM];

    assign in_left[0]  = row_item.left_col0;
    assign in_left[1]  = row_item.left_col1;
    assign in_left[2]  = row_item.left_col2;
    assign in_left[3]  = row_item.left_col3;
    assign in_right[0] = row_item.right_col0;
    assign in_right[1] = row_item.right_col1;
    assign in_right[2] = row_item.right_col2;
    assign in_right[3] = row_item.right_col3;

    // Pipeline moves unless a finished row is held at the output
    assign en         = !prod_valid || !prod_stall;
    assign row_stall  = (state_reg == mm4_pkg::ST_RUN);
    assign row_accept = row_valid && !row_stall;

    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        issue_row_next   = issue_row_reg;
        issue_tag.valid  = 1'b0;
        issue_tag.row    = issue_row_reg;
        case (state_reg)
            mm4_pkg::ST_LOAD:
            begin
                if (row_accept)
                begin
                    if (rows_loaded_reg == ROW_W'(DIM - 1))
                    begin
                        rows_loaded_next = '0;
                        state_next       = mm4_pkg::ST_RUN;
                    end
                    else
                        rows_loaded_next = rows_loaded_reg + ROW_W'(1);
                end
            end
            mm4_pkg::ST_RUN:
            begin
                issue_tag.valid = 1'b1;
                if (en)
                begin
                    // stores are used only by issued rows; the last issue frees them
                    if (issue_row_reg == ROW_W'(DIM - 1))
                    begin
                        issue_row_next = '0;
                        state_next     = mm4_pkg::ST_LOAD;
                    end
                    else
                        issue_row_next = issue_row_reg + ROW_W'(1);
                end
            end
            default:
            begin
                state_next = mm4_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mm4_pkg::ST_LOAD;
            rows_loaded_reg <= '0;
            issue_row_reg   <= '0;
            tag1_reg        <= '0;
            tag2_reg        <= '0;
            tag3_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_loaded_reg <= rows_loaded_next;
            issue_row_reg   <= issue_row_next;
            if (en)
            begin
                tag1_reg <= issue_tag;
                tag2_reg <= tag1_reg;
                tag3_reg <= tag2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_accept)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                left_reg[rows_loaded_reg][c]  <= in_left[c];
                right_reg[rows_loaded_reg][c] <= in_right[c];
            end
        end
    end

    always_comb
    begin
        a_row = left_reg[issue_row_reg];
        for (int c = 0; c < DIM; c++)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                b_col[c][k] = right_reg[k][c];
            end
        end
    end

    // One lane per column of C
    for (genvar c = 0; c < DIM; c++)
    begin : g_lane
        mm4_lane u_lane (
            .clk   (clk),
            .en    (en),
            .a_row (a_row),
            .b_col (b_col[c]),
            .sum   (lane_sum[c])
        );
    end

    mm4_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .tag   (tag3_reg),
        .sums  (lane_sum),
        .valid (prod_valid),
        .item  (prod_item)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mm4_check.sv
`default_nettype none

module mm4_check (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 row_valid,
    input wire logic                 row_stall,
    input wire logic                 prod_valid,
    input wire logic                 prod_stall,
    input wire mm4_pkg::prod_item_t  prod_item
);

    localparam int ROW_W = mm4_pkg::ROW_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(mm4_pkg::DIM - 1);

    logic [ROW_W-1:0] loaded_reg;
    logic [ROW_W-1:0] exp_row_reg;
    logic             row_acc;
    logic             prod_acc;

    assign row_acc  = row_valid && !row_stall;
    assign prod_acc = prod_valid && !prod_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg  <= '0;
            exp_row_reg <= '0;
        end
        else
        begin
            if (row_acc)
                loaded_reg <= (loaded_reg == LAST_ROW) ? '0 : loaded_reg + ROW_W'(1);
            if (prod_acc)
                exp_row_reg <= (exp_row_reg == LAST_ROW) ? '0 : exp_row_reg + ROW_W'(1);
        end
    end

    // a held product row stays put
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && prod_stall |=> prod_valid && $stable(prod_item))
        else $error("product item changed while stalled");

    // product rows leave in order 0..DIM-1
    a_prod_order: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> prod_item.product_row == exp_row_reg)
        else $error("product row out of order");

    a_final_mark: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> prod_item.final_row == (prod_item.product_row == LAST_ROW))
        else $error("final_row mark wrong");

    // the last row of a pair stops loading while products are issued
    a_run_stall: assert property (@(posedge clk) disable iff (!rst_n)
        row_acc && loaded_reg == LAST_ROW |=> row_stall)
        else $error("row channel open after last row");

endmodule

bind matrix_multiply_4x4_top mm4_check u_check (.*);

`default_nettype wire
